>>> rtl/cau_pkg.sv
// shared types and codes of the complex arithmetic unit
package cau_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_NEG  = 3'd4,
        OP_CONJ = 3'd5,
        OP_NOP6 = 3'd6,
        OP_NOP7 = 3'd7
    } cau_op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } cau_status_e;

    // control that travels with every item through the pipeline
    typedef struct packed {
        logic    valid;
        cau_op_e op;
    } cau_ctrl_t;

endpackage

>>> rtl/cau_if.sv
// operand and result channels of the complex arithmetic unit
interface cau_in_if #(parameter int DATA_WIDTH = 16);
    import cau_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              op;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;

    modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int DATA_WIDTH = 16);
    import cau_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] r_re;
    logic signed [DATA_WIDTH-1:0] r_im;
    logic [STATUS_W-1:0]          status;

    modport source (output valid, r_re, r_im, status, input ready);
    modport sink (input valid, r_re, r_im, status, output ready);
endinterface

>>> rtl/cau_mult.sv
// first stage: all operand products, registered
module cau_mult #(
    parameter int DW = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ce,
    input  cau_pkg::cau_ctrl_t       ctrl,
    input  logic signed [DW-1:0]     a_re,
    input  logic signed [DW-1:0]     a_im,
    input  logic signed [DW-1:0]     b_re,
    input  logic signed [DW-1:0]     b_im,
    output cau_pkg::cau_ctrl_t       ctrl_reg,
    output logic signed [DW-1:0]     a_re_reg,
    output logic signed [DW-1:0]     a_im_reg,
    output logic signed [DW-1:0]     b_re_reg,
    output logic signed [DW-1:0]     b_im_reg,
    output logic signed [2*DW-1:0]   p_rr_reg,
    output logic signed [2*DW-1:0]   p_ii_reg,
    output logic signed [2*DW-1:0]   p_ri_reg,
    output logic signed [2*DW-1:0]   p_ir_reg,
    output logic signed [2*DW-1:0]   p_bb_re_reg,
    output logic signed [2*DW-1:0]   p_bb_im_reg
);
    import cau_pkg::*;

    localparam int PW = 2 * DW;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '{valid: 1'b0, op: OP_ADD};
        end
        else if (ce)
        begin
            ctrl_reg <= ctrl;
        end
    end

    // products and operand copies
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_re_reg    <= a_re;
            a_im_reg    <= a_im;
            b_re_reg    <= b_re;
            b_im_reg    <= b_im;
            p_rr_reg    <= PW'(a_re) * PW'(b_re);
            p_ii_reg    <= PW'(a_im) * PW'(b_im);
            p_ri_reg    <= PW'(a_re) * PW'(b_im);
            p_ir_reg    <= PW'(a_im) * PW'(b_re);
            p_bb_re_reg <= PW'(b_re) * PW'(b_re);
            p_bb_im_reg <= PW'(b_im) * PW'(b_im);
        end
    end

endmodule

>>> rtl/cau_comb.sv
// second stage: sums per opcode, sign-magnitude split, divisor |b|^2
module cau_comb #(
    parameter int DW = 16,
    parameter int FB = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ce,
    input  cau_pkg::cau_ctrl_t       ctrl,
    input  logic signed [DW-1:0]     a_re,
    input  logic signed [DW-1:0]     a_im,
    input  logic signed [DW-1:0]     b_re,
    input  logic signed [DW-1:0]     b_im,
    input  logic signed [2*DW-1:0]   p_rr,
    input  logic signed [2*DW-1:0]   p_ii,
    input  logic signed [2*DW-1:0]   p_ri,
    input  logic signed [2*DW-1:0]   p_ir,
    input  logic signed [2*DW-1:0]   p_bb_re,
    input  logic signed [2*DW-1:0]   p_bb_im,
    output cau_pkg::cau_ctrl_t       ctrl_reg,
    output logic                     neg_re_reg,
    output logic                     neg_im_reg,
    output logic [2*DW-1:0]          mag_re_reg,
    output logic [2*DW-1:0]          mag_im_reg,
    output logic [2*DW-1:0]          den_reg,
    output logic                     dz_reg
);
    import cau_pkg::*;

    localparam int SW = 2 * DW + 1;
    localparam int MW = 2 * DW;

    logic signed [SW-1:0] v_re;
    logic signed [SW-1:0] v_im;
    logic [SW-1:0]        abs_re;
    logic [SW-1:0]        abs_im;
    logic [MW-1:0]        mag_re_next;
    logic [MW-1:0]        mag_im_next;
    logic [MW-1:0]        den_next;

    // exact signed value of each part
    always_comb
    begin
        unique case (ctrl.op)
            OP_ADD:
            begin
                v_re = SW'(a_re) + SW'(b_re);
                v_im = SW'(a_im) + SW'(b_im);
            end
            OP_SUB:
            begin
                v_re = SW'(a_re) - SW'(b_re);
                v_im = SW'(a_im) - SW'(b_im);
            end
            OP_MUL:
            begin
                v_re = SW'(p_rr) - SW'(p_ii);
                v_im = SW'(p_ri) + SW'(p_ir);
            end
            OP_DIV:
            begin
                v_re = SW'(p_rr) + SW'(p_ii);
                v_im = SW'(p_ir) - SW'(p_ri);
            end
            OP_NEG:
            begin
                v_re = -SW'(a_re);
                v_im = -SW'(a_im);
            end
            OP_CONJ:
            begin
                v_re = SW'(a_re);
                v_im = -SW'(a_im);
            end
            default:
            begin
                v_re = '0;
                v_im = '0;
            end
        endcase
    end

    // magnitudes, products truncated toward zero
    always_comb
    begin
        abs_re = v_re[SW-1] ? $unsigned(-v_re) : $unsigned(v_re);
        abs_im = v_im[SW-1] ? $unsigned(-v_im) : $unsigned(v_im);
        if (ctrl.op == OP_MUL)
        begin
            mag_re_next = abs_re[MW-1:0] >> FB;
            mag_im_next = abs_im[MW-1:0] >> FB;
        end
        else
        begin
            mag_re_next = abs_re[MW-1:0];
            mag_im_next = abs_im[MW-1:0];
        end
        den_next = $unsigned(p_bb_re) + $unsigned(p_bb_im);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '{valid: 1'b0, op: OP_ADD};
        end
        else if (ce)
        begin
            ctrl_reg <= ctrl;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg_re_reg <= v_re[SW-1];
            neg_im_reg <= v_im[SW-1];
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            den_reg    <= den_next;
            dz_reg     <= (ctrl.op == OP_DIV) && (b_re == '0) && (b_im == '0);
        end
    end

endmodule

>>> rtl/cau_div_stage.sv
// one restoring-division step: quotient bit IDX of both parts
module cau_div_stage #(
    parameter int DW  = 16,
    parameter int FB  = 8,
    parameter int IDX = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ce,
    input  cau_pkg::cau_ctrl_t       ctrl,
    input  logic                     neg_re,
    input  logic                     neg_im,
    input  logic                     dz,
    input  logic [2*DW-1:0]          den,
    input  logic [3*DW+FB:0]         rem_re,
    input  logic [3*DW+FB:0]         rem_im,
    input  logic [DW+1:0]            q_re,
    input  logic [DW+1:0]            q_im,
    output cau_pkg::cau_ctrl_t       ctrl_reg,
    output logic                     neg_re_reg,
    output logic                     neg_im_reg,
    output logic                     dz_reg,
    output logic [2*DW-1:0]          den_reg,
    output logic [3*DW+FB:0]         rem_re_reg,
    output logic [3*DW+FB:0]         rem_im_reg,
    output logic [DW+1:0]            q_re_reg,
    output logic [DW+1:0]            q_im_reg
);
    import cau_pkg::*;

    localparam int CW = 3 * DW + FB + 1;

    logic [CW-1:0]   dsh;
    logic            is_div;
    logic            take_re;
    logic            take_im;
    logic [CW-1:0]   rem_re_next;
    logic [CW-1:0]   rem_im_next;
    logic [DW+1:0]   q_re_next;
    logic [DW+1:0]   q_im_next;

    // trial subtract of the shifted divisor
    always_comb
    begin
        dsh         = CW'(den) << IDX;
        is_div      = (ctrl.op == OP_DIV);
        take_re     = is_div && (rem_re >= dsh);
        take_im     = is_div && (rem_im >= dsh);
        rem_re_next = take_re ? rem_re - dsh : rem_re;
        rem_im_next = take_im ? rem_im - dsh : rem_im;
        q_re_next      = q_re;
        q_im_next      = q_im;
        q_re_next[IDX] = take_re;
        q_im_next[IDX] = take_im;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '{valid: 1'b0, op: OP_ADD};
        end
        else if (ce)
        begin
            ctrl_reg <= ctrl;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg_re_reg <= neg_re;
            neg_im_reg <= neg_im;
            dz_reg     <= dz;
            den_reg    <= den;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
        end
    end

endmodule

>>> rtl/cau_sat.sv
// last stage: result select, saturation, status, output register
module cau_sat #(
    parameter int DW = 16,
    parameter int FB = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     ce,
    input  cau_pkg::cau_ctrl_t       ctrl,
    input  logic                     neg_re,
    input  logic                     neg_im,
    input  logic                     dz,
    input  logic [3*DW+FB:0]         rem_re,
    input  logic [3*DW+FB:0]         rem_im,
    input  logic [DW+1:0]            q_re,
    input  logic [DW+1:0]            q_im,
    output logic                     valid_reg,
    output logic signed [DW-1:0]     r_re_reg,
    output logic signed [DW-1:0]     r_im_reg,
    output logic [cau_pkg::STATUS_W-1:0] status_reg
);
    import cau_pkg::*;

    localparam int CW = 3 * DW + FB + 1;
    localparam logic [CW-1:0] HALF = CW'(1) << (DW - 1);

    logic [CW-1:0]   mag_re;
    logic [CW-1:0]   mag_im;
    logic [DW-1:0]   sat_re;
    logic [DW-1:0]   sat_im;
    logic            clip_re;
    logic            clip_im;
    cau_status_e     status_next;

    // clamp one sign-magnitude part to the signed field range
    function automatic logic [DW:0] clamp(input logic neg, input logic [CW-1:0] mag);
        logic [CW-1:0] neg_mag;
        logic [DW:0]   res;
        neg_mag = -mag;
        if (neg)
        begin
            if (mag > HALF)
                res = {1'b1, 1'b1, {(DW-1){1'b0}}};
            else
                res = {1'b0, neg_mag[DW-1:0]};
        end
        else
        begin
            if (mag > HALF - CW'(1))
                res = {1'b1, 1'b0, {(DW-1){1'b1}}};
            else
                res = {1'b0, mag[DW-1:0]};
        end
        return res;
    endfunction

    // quotient for division, plain magnitude otherwise
    always_comb
    begin
        mag_re = (ctrl.op == OP_DIV) ? CW'(q_re) : rem_re;
        mag_im = (ctrl.op == OP_DIV) ? CW'(q_im) : rem_im;
        {clip_re, sat_re} = clamp(neg_re, mag_re);
        {clip_im, sat_im} = clamp(neg_im, mag_im);
        priority if (dz)
            status_next = ST_DIVZ;
        else if (clip_re || clip_im)
            status_next = ST_SAT;
        else
            status_next = ST_OK;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= ctrl.valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_re_reg   <= dz ? '0 : $signed(sat_re);
            r_im_reg   <= dz ? '0 : $signed(sat_im);
            status_reg <= status_next;
        end
    end

endmodule

>>> rtl/complex_arithmetic_unit.sv
// top level of the pipelined complex arithmetic unit
//
// Channels: cmd carries op and the operands a and b (signed fixed point,
// FRAC_BITS fraction bits); res carries r_re, r_im and status. Both use
// valid/ready; an item moves when valid and ready are high at a clock edge.
// Ops: add, subtract, multiply, divide, negate a, conjugate a. Products and
// quotients are truncated toward zero; parts that leave the range clamp and
// give status saturated; division by zero gives zero with its own status.
// Stages from acceptance to res.valid: one multiply stage, one sum stage,
// one stage for each of the DATA_WIDTH + 2 quotient bits of the restoring
// divider, one output register. Every op goes through the same stages.
// Throughput: one item per cycle. The whole pipeline advances together
// whenever the output register is empty or being taken, so cmd.ready is low
// only while a result waits at res and the receiver holds ready low; nothing
// is lost or repeated across a stall.
// Reset: rst_n clears all valid bits; the pipeline comes up empty.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    cau_in_if.sink      cmd,
    cau_out_if.source   res
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int MW = 2 * DW;
    localparam int CW = 3 * DW + FB + 1;
    localparam int QW = DW + 2;

    logic                 ce;
    cau_ctrl_t            in_ctrl;

    cau_ctrl_t            m_ctrl;
    logic signed [DW-1:0] m_a_re;
    logic signed [DW-1:0] m_a_im;
    logic signed [DW-1:0] m_b_re;
    logic signed [DW-1:0] m_b_im;
    logic signed [MW-1:0] m_p_rr;
    logic signed [MW-1:0] m_p_ii;
    logic signed [MW-1:0] m_p_ri;
    logic signed [MW-1:0] m_p_ir;
    logic signed [MW-1:0] m_p_bb_re;
    logic signed [MW-1:0] m_p_bb_im;

    cau_ctrl_t            c_ctrl;
    logic                 c_neg_re;
    logic                 c_neg_im;
    logic [MW-1:0]        c_mag_re;
    logic [MW-1:0]        c_mag_im;
    logic [MW-1:0]        c_den;
    logic                 c_dz;

    cau_ctrl_t            d_ctrl   [QW+1];
    logic                 d_neg_re [QW+1];
    logic                 d_neg_im [QW+1];
    logic                 d_dz     [QW+1];
    logic [MW-1:0]        d_den    [QW+1];
    logic [CW-1:0]        d_rem_re [QW+1];
    logic [CW-1:0]        d_rem_im [QW+1];
    logic [QW-1:0]        d_q_re   [QW+1];
    logic [QW-1:0]        d_q_im   [QW+1];

    // global advance: output register empty or being taken
    assign ce        = !res.valid || res.ready;
    assign cmd.ready = ce;
    assign in_ctrl   = '{valid: cmd.valid, op: cau_op_e'(cmd.op)};

    cau_mult #(.DW(DW)) u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .ce          (ce),
        .ctrl        (in_ctrl),
        .a_re        (cmd.a_re),
        .a_im        (cmd.a_im),
        .b_re        (cmd.b_re),
        .b_im        (cmd.b_im),
        .ctrl_reg    (m_ctrl),
        .a_re_reg    (m_a_re),
        .a_im_reg    (m_a_im),
        .b_re_reg    (m_b_re),
        .b_im_reg    (m_b_im),
        .p_rr_reg    (m_p_rr),
        .p_ii_reg    (m_p_ii),
        .p_ri_reg    (m_p_ri),
        .p_ir_reg    (m_p_ir),
        .p_bb_re_reg (m_p_bb_re),
        .p_bb_im_reg (m_p_bb_im)
    );

    cau_comb #(.DW(DW), .FB(FB)) u_comb (
        .clk        (clk),
        .rst_n      (rst_n),
        .ce         (ce),
        .ctrl       (m_ctrl),
        .a_re       (m_a_re),
        .a_im       (m_a_im),
        .b_re       (m_b_re),
        .b_im       (m_b_im),
        .p_rr       (m_p_rr),
        .p_ii       (m_p_ii),
        .p_ri       (m_p_ri),
        .p_ir       (m_p_ir),
        .p_bb_re    (m_p_bb_re),
        .p_bb_im    (m_p_bb_im),
        .ctrl_reg   (c_ctrl),
        .neg_re_reg (c_neg_re),
        .neg_im_reg (c_neg_im),
        .mag_re_reg (c_mag_re),
        .mag_im_reg (c_mag_im),
        .den_reg    (c_den),
        .dz_reg     (c_dz)
    );

    // divider entry: dividend scaled by the fraction bits
    assign d_ctrl[0]   = c_ctrl;
    assign d_neg_re[0] = c_neg_re;
    assign d_neg_im[0] = c_neg_im;
    assign d_dz[0]     = c_dz;
    assign d_den[0]    = c_den;
    assign d_rem_re[0] = (c_ctrl.op == OP_DIV) ? CW'(c_mag_re) << FB : CW'(c_mag_re);
    assign d_rem_im[0] = (c_ctrl.op == OP_DIV) ? CW'(c_mag_im) << FB : CW'(c_mag_im);
    assign d_q_re[0]   = '0;
    assign d_q_im[0]   = '0;

    // one stage per quotient bit, most significant first
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        cau_div_stage #(.DW(DW), .FB(FB), .IDX(QW - 1 - k)) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .ce         (ce),
            .ctrl       (d_ctrl[k]),
            .neg_re     (d_neg_re[k]),
            .neg_im     (d_neg_im[k]),
            .dz         (d_dz[k]),
            .den        (d_den[k]),
            .rem_re     (d_rem_re[k]),
            .rem_im     (d_rem_im[k]),
            .q_re       (d_q_re[k]),
            .q_im       (d_q_im[k]),
            .ctrl_reg   (d_ctrl[k+1]),
            .neg_re_reg (d_neg_re[k+1]),
            .neg_im_reg (d_neg_im[k+1]),
            .dz_reg     (d_dz[k+1]),
            .den_reg    (d_den[k+1]),
            .rem_re_reg (d_rem_re[k+1]),
            .rem_im_reg (d_rem_im[k+1]),
            .q_re_reg   (d_q_re[k+1]),
            .q_im_reg   (d_q_im[k+1])
        );
    end

    cau_sat #(.DW(DW), .FB(FB)) u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .ce         (ce),
        .ctrl       (d_ctrl[QW]),
        .neg_re     (d_neg_re[QW]),
        .neg_im     (d_neg_im[QW]),
        .dz         (d_dz[QW]),
        .rem_re     (d_rem_re[QW]),
        .rem_im     (d_rem_im[QW]),
        .q_re       (d_q_re[QW]),
        .q_im       (d_q_im[QW]),
        .valid_reg  (res.valid),
        .r_re_reg   (res.r_re),
        .r_im_reg   (res.r_im),
        .status_reg (res.status)
    );

    // division by zero always gives a zero result
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_DIVZ) |-> (res.r_re == '0 && res.r_im == '0))
        else $error("division by zero with nonzero result");

    // the unused status code never appears
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.status == ST_OK || res.status == ST_DIVZ
                       || res.status == ST_SAT))
        else $error("undefined status code");

    // a saturated result has at least one part on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_SAT) |->
            (res.r_re == {1'b0, {(DW-1){1'b1}}} || res.r_re == {1'b1, {(DW-1){1'b0}}}
             || res.r_im == {1'b0, {(DW-1){1'b1}}} || res.r_im == {1'b1, {(DW-1){1'b0}}}))
        else $error("saturation status without a clamped part");

endmodule

>>> tb/complex_arithmetic_unit_tb.sv
// complex arithmetic unit testbench: directed table, then random items, checked by table or predictor
module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW   = 16;
    localparam int FB   = 8;
    localparam int LAT  = DW + 5;
    localparam int N_RANDOM = 1250;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
        bit               known;
        logic signed [DW-1:0] r_re;
        logic signed [DW-1:0] r_im;
        logic [STATUS_W-1:0]  status;
    } vec_t;

    typedef struct {
        logic signed [DW-1:0] r_re;
        logic signed [DW-1:0] r_im;
        logic [STATUS_W-1:0]  status;
    } result_t;

    logic clk;
    logic rst_n;
    cau_in_if  #(.DATA_WIDTH(DW)) cmd ();
    cau_out_if #(.DATA_WIDTH(DW)) res ();

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct;
    int      recv_idle_pct;

    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE  = 16'sd256;

    // clamp a wide signed value, flag clamping
    function automatic logic signed [DW-1:0] clamp(input longint v, inout bit sat);
        if (v > longint'(MAXV))
        begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < longint'(MINV))
        begin
            sat = 1'b1;
            return MINV;
        end
        return v[DW-1:0];
    endfunction

    // truncate toward zero: magnitude shifted down
    function automatic longint shr_tz(input longint v);
        return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
    endfunction

    // magnitude quotient scaled by 2^FB, capped like the divider
    function automatic longint div_tz(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        if (q >= (longint'(1) << DW))
            q = longint'(1) << (DW + FB);
        else
            q = (mag << FB) / den;
        return (num < 0) ? -q : q;
    endfunction

    // expected result of one operand item
    function automatic result_t compute_complex(input vec_t v);
        result_t r;
        longint re, im, den;
        bit sat;
        longint ar, ai, br, bi;
        ar = v.a_re; ai = v.a_im; br = v.b_re; bi = v.b_im;
        re = 0; im = 0; sat = 1'b0;
        r.status = ST_OK;
        case (cau_op_e'(v.op))
            OP_ADD:  begin re = ar + br; im = ai + bi; end
            OP_SUB:  begin re = ar - br; im = ai - bi; end
            OP_MUL:
            begin
                re = shr_tz(ar * br - ai * bi);
                im = shr_tz(ar * bi + ai * br);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.status = ST_DIVZ;
                else
                begin
                    re = div_tz(ar * br + ai * bi, den);
                    im = div_tz(ai * br - ar * bi, den);
                end
            end
            OP_NEG:  begin re = -ar; im = -ai; end
            OP_CONJ: begin re = ar; im = -ai; end
            default: ;
        endcase
        r.r_re = clamp(re, sat);
        r.r_im = clamp(im, sat);
        if (r.status == ST_OK && sat)
            r.status = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, driven at falling edge
    always @(negedge clk)
        res.ready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("queued results", 0, 1);
            end
            else
            begin
                w = pending_results.pop_front();
                if (res.r_re !== w.r_re)
                    report_mismatch("r_re", res.r_re, w.r_re);
                if (res.r_im !== w.r_im)
                    report_mismatch("r_im", res.r_im, w.r_im);
                if (res.status !== w.status)
                    report_mismatch("status", res.status, w.status);
            end
        end
    end

    // drive one item, with sender idling, until accepted
    task automatic send_item(input vec_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.op    <= v.op;
        cmd.a_re  <= v.a_re;
        cmd.a_im  <= v.a_im;
        cmd.b_re  <= v.b_re;
        cmd.b_im  <= v.b_im;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (v.known)
            pending_results.push_back('{v.r_re, v.r_im, v.status});
        else
            pending_results.push_back(compute_complex(v));
        @(negedge clk);
    endtask

    function automatic logic signed [DW-1:0] rand_part();
        case ($urandom_range(5))
            0: return MAXV;
            1: return MINV;
            2: return DW'($urandom_range(1023) - 512);
            3: return '0;
            default: return DW'($urandom);
        endcase
    endfunction

    // directed table; known rows carry their result
    vec_t directed[] = '{
        '{OP_ADD,  MAXV, MINV, MAXV, MINV, 1, MAXV, MINV, ST_SAT},
        '{OP_ADD,  ONE, -ONE, ONE, ONE, 1, 16'sd512, 16'sd0, ST_OK},
        '{OP_SUB,  MINV, MAXV, 16'sd1, -16'sd1, 1, MINV, MAXV, ST_SAT},
        '{OP_SUB,  16'sd5, 16'sd7, 16'sd2, 16'sd9, 1, 16'sd3, -16'sd2, ST_OK},
        '{OP_MUL,  ONE, 16'sd0, ONE, 16'sd0, 1, ONE, 16'sd0, ST_OK},
        '{OP_MUL,  MAXV, MAXV, MAXV, MAXV, 0, 0, 0, ST_OK},
        '{OP_MUL,  MINV, MINV, MINV, MINV, 0, 0, 0, ST_OK},
        '{OP_MUL,  -16'sd1, 16'sd1, 16'sd1, 16'sd1, 0, 0, 0, ST_OK},
        '{OP_DIV,  ONE, ONE, 16'sd0, 16'sd0, 1, 16'sd0, 16'sd0, ST_DIVZ},
        '{OP_DIV,  ONE, 16'sd0, ONE, 16'sd0, 1, ONE, 16'sd0, ST_OK},
        '{OP_DIV,  MAXV, MINV, 16'sd1, 16'sd0, 0, 0, 0, ST_OK},
        '{OP_DIV,  MINV, MAXV, MINV, MINV, 0, 0, 0, ST_OK},
        '{OP_DIV,  -16'sd3, 16'sd7, 16'sd0, -16'sd1, 0, 0, 0, ST_OK},
        '{OP_DIV,  16'sd1, -16'sd1, MAXV, MAXV, 0, 0, 0, ST_OK},
        '{OP_NEG,  MINV, MINV, 16'sd0, 16'sd0, 1, MAXV, MAXV, ST_SAT},
        '{OP_NEG,  MAXV, 16'sd0, 16'sd0, 16'sd0, 1, -MAXV, 16'sd0, ST_OK},
        '{OP_CONJ, MINV, MINV, 16'sd0, 16'sd0, 1, MINV, MAXV, ST_SAT},
        '{OP_CONJ, MAXV, MAXV, 16'sd0, 16'sd0, 1, MAXV, -MAXV, ST_OK},
        '{OP_NOP6, MAXV, MINV, MAXV, MINV, 1, 16'sd0, 16'sd0, ST_OK},
        '{OP_NOP7, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1, 16'sd0, 16'sd0, ST_OK}
    };

    // stimulus sequence
    initial
    begin
        vec_t v;
        int phase;
        int k;
        send_idle_pct = 6;
        recv_idle_pct = 80;
        rst_n     = 1'b0;
        cmd.valid = 1'b0;
        cmd.op    = '0;
        cmd.a_re  = '0;
        cmd.a_im  = '0;
        cmd.b_re  = '0;
        cmd.b_im  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_item(directed[i]);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 6 : 0;
            for (k = 0; k < N_RANDOM / 3; k++)
            begin
                v.op    = ($urandom_range(15) == 0) ? OP_W'($urandom_range(7, 6))
                                                    : OP_W'($urandom_range(5));
                v.a_re  = rand_part();
                v.a_im  = rand_part();
                v.b_re  = ($urandom_range(19) == 0) ? 16'sd0 : rand_part();
                v.b_im  = ($urandom_range(19) == 0) ? 16'sd0 : rand_part();
                v.known = 1'b0;
                send_item(v);
                // hold off until the pipeline has drained
                if (k == 100)
                begin
                    cmd.valid <= 1'b0;
                    @(negedge clk);
                    while (pending_results.size() != 0)
                        @(negedge clk);
                end
            end
        end

        cmd.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * LAT) @(negedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
